[hw/rtl/pht_pkg.sv]
// Shared types, constants and helpers for the polyline hit test block.
// Used by every module under hw/rtl; depends on nothing.
package pht_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int CNT_W        = 13;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;
	localparam int RAD_W        = 66;
	localparam int ROOT_W       = 34;
	localparam int REM_W        = 37;
	localparam int CMP_W        = 37;
	localparam int SUM_W        = 37;

	localparam logic [1:0] REG_QUERY_X     = 2'd0;
	localparam logic [1:0] REG_QUERY_Y     = 2'd1;
	localparam logic [1:0] REG_PICK_RADIUS = 2'd2;

	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
		logic               test;
		logic [CNT_W-1:0]   index;
		logic               last;
	} job_t;

	typedef struct packed {
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic [30:0]        pick_radius;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_CMP, ST_MUL, ST_DIV, ST_FIX, ST_DONE
	} state_t;

	// magnitude of a difference of two 32-bit values; always below 2^32
	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] n;
		n = v[32] ? 33'(-v) : 33'(v);
		return n[31:0];
	endfunction

endpackage

[hw/rtl/polyline_hit_test_insert.sv]
// Top level of the polyline hit test: register port, front end, job queue, back end.
// Depends on pht_pkg, pht_front, pht_fifo, pht_back.
//
//   port group                  direction  transfer when
//   vertex_x/vertex_y/last      in         push && !full
//   hit/insert_index/new_x/y    out        pop && !empty
//   psel/penable/paddr/pwdata   cfg        psel && penable && pwrite (pready high)
//
// On a miss a tested segment passes through the back end as a pick-up step, three
// distances of two multiplier steps plus 33 root steps, a compare and a result step.
// A hit on a segment of non-zero length adds a multiply, 64 divide steps and a fix-up
// step. Untested vertices pass through the pick-up and result steps only. The front
// end keeps taking vertices while the four-entry job queue has room; a waiting result
// stalls the back end only. Reset clears all control state at once.
module polyline_hit_test_insert import pht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic               last_vertex,
	output logic               empty,
	input  logic               pop,
	output logic               hit,
	output logic [CNT_W-1:0]   insert_index,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg_q;
	job_t job, fifo_data;
	logic job_push, fifo_full, fifo_empty, fifo_pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_QUERY_X:     cfg_q.query_x     <= pwdata;
				REG_QUERY_Y:     cfg_q.query_y     <= pwdata;
				REG_PICK_RADIUS: cfg_q.pick_radius <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_QUERY_X:     prdata = cfg_q.query_x;
			REG_QUERY_Y:     prdata = cfg_q.query_y;
			REG_PICK_RADIUS: prdata = {1'b0, cfg_q.pick_radius};
			default:         prdata = '0;
		endcase
	end

	pht_front u_front (
		.clk, .arst_n, .push, .vertex_x, .vertex_y, .last_vertex,
		.fifo_full, .full, .job_push, .job
	);

	pht_fifo u_fifo (
		.clk, .arst_n, .wr_en(job_push), .wr_data(job), .rd_en(fifo_pop),
		.rd_data(fifo_data), .full(fifo_full), .empty(fifo_empty)
	);

	pht_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .fifo_empty, .fifo_data, .fifo_pop,
		.pop, .empty, .hit, .insert_index, .new_x, .new_y
	);

endmodule

[hw/rtl/pht_front.sv]
// Front end: accepts vertices, pairs each with the previous one into a segment job.
// Depends on pht_pkg.
module pht_front import pht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic               last_vertex,
	input  logic               fifo_full,
	output logic               full,
	output logic               job_push,
	output job_t               job
);

	logic               have_prev_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [31:0] prev_x_q;
	logic signed [31:0] prev_y_q;
	logic               room;

	assign full     = fifo_full;
	assign job_push = push && !fifo_full;
	assign room     = cnt_q < CNT_W'(MAX_VERTICES - 1);

	always_comb begin
		job.x1    = prev_x_q;
		job.y1    = prev_y_q;
		job.x2    = vertex_x;
		job.y2    = vertex_y;
		job.test  = have_prev_q && room;
		job.index = cnt_q + CNT_W'(1);
		job.last  = last_vertex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else if (job_push) begin
			if (last_vertex) begin
				have_prev_q <= 1'b0;
				cnt_q       <= '0;
				prev_x_q    <= '0;
				prev_y_q    <= '0;
			end else begin
				have_prev_q <= 1'b1;
				prev_x_q    <= vertex_x;
				prev_y_q    <= vertex_y;
				if (have_prev_q && room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

[hw/rtl/pht_fifo.sv]
// Short job queue between the front end and the compute back end.
// Depends on pht_pkg.
module pht_fifo import pht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full    = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
		end
	end

endmodule

[hw/rtl/pht_back.sv]
// Back end: distance test, interpolation and result register, on one shared
// multiplier, a radix-2 square root and a restoring divider. Depends on pht_pkg.
module pht_back import pht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               fifo_empty,
	input  job_t               fifo_data,
	output logic               fifo_pop,
	input  logic               pop,
	output logic               empty,
	output logic               hit,
	output logic [CNT_W-1:0]   insert_index,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y
);

	state_t state_q, state_d;
	logic   found_q;
	logic   res_valid_q;
	logic   hitflag_q;
	logic [1:0] sel_q;
	logic [5:0] cnt_q;

	job_t               j_q;
	logic [63:0]        sq_q;
	logic [RAD_W-1:0]   rad_q;
	logic [ROOT_W-1:0]  root_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  d_q [3];
	logic signed [32:0] ia_q, ib_q, iden_q;
	logic signed [31:0] ibase_q;
	logic               ixaxis_q;
	logic [63:0]        quo_q;
	logic [31:0]        drem_q;
	logic               neg_q;
	logic signed [31:0] nx_q, ny_q;

	// distance operands
	logic signed [31:0] ax, ay, bx, by;
	logic [31:0]        mdx, mdy, mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [REM_W-1:0]   rem_sh, trial;
	logic               sq_ok;
	logic [CMP_W-1:0]   lhs, rhs;
	logic               is_hit;
	logic signed [32:0] ex, ey;
	logic [31:0]        adx, ady;
	logic [32:0]        dsh;
	logic               d_ok;
	logic               sat;
	logic signed [SUM_W-1:0] vsum;
	logic signed [31:0] vres;
	logic               emit;

	always_comb begin
		unique case (sel_q)
			2'd0:    begin ax = j_q.x1; ay = j_q.y1; bx = cfg.query_x; by = cfg.query_y; end
			2'd1:    begin ax = j_q.x2; ay = j_q.y2; bx = cfg.query_x; by = cfg.query_y; end
			default: begin ax = j_q.x1; ay = j_q.y1; bx = j_q.x2;      by = j_q.y2;      end
		endcase
	end

	assign mdx = mag33(33'(ax) - 33'(bx));
	assign mdy = mag33(33'(ay) - 33'(by));

	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = mag33(ia_q);
			mul_b = mag33(ib_q);
		end else if (state_q == ST_SQY) begin
			mul_a = mdy;
			mul_b = mdy;
		end else begin
			mul_a = mdx;
			mul_b = mdx;
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// one root digit per cycle
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign sq_ok  = rem_sh >= trial;

	assign lhs    = (CMP_W'(d_q[0]) + CMP_W'(d_q[1])) << 1;
	assign rhs    = (CMP_W'(d_q[2]) << 1) + CMP_W'(cfg.pick_radius) * CMP_W'(3);
	assign is_hit = lhs < rhs;

	assign ex  = 33'(j_q.x2) - 33'(j_q.x1);
	assign ey  = 33'(j_q.y2) - 33'(j_q.y1);
	assign adx = mag33(ex);
	assign ady = mag33(ey);

	assign dsh  = {drem_q, quo_q[63]};
	assign d_ok = dsh >= {1'b0, mag33(iden_q)};

	// saturate when the quotient leaves the 2^34 window, then add to base
	assign sat  = (quo_q[63:35] != '0) || (quo_q[34] && (quo_q[33:0] != '0));
	assign vsum = neg_q ? SUM_W'(ibase_q) - SUM_W'({1'b0, quo_q[34:0]})
	                    : SUM_W'(ibase_q) + SUM_W'({1'b0, quo_q[34:0]});
	always_comb begin
		if (sat) begin
			vres = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (vsum > SUM_W'(32'sh7fff_ffff)) begin
			vres = 32'sh7fff_ffff;
		end else if (vsum < SUM_W'(32'sh8000_0000)) begin
			vres = 32'sh8000_0000;
		end else begin
			vres = vsum[31:0];
		end
	end

	assign emit = hitflag_q || (j_q.last && !found_q);

	always_comb begin
		state_d  = state_q;
		fifo_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!fifo_empty && !res_valid_q) begin
					fifo_pop = 1'b1;
					state_d  = (fifo_data.test && !found_q) ? ST_SQX : ST_DONE;
				end
			end
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == '0) begin
					state_d = (sel_q == 2'd2) ? ST_CMP : ST_SQX;
				end
			end
			ST_CMP: begin
				if (is_hit && (adx > ady || ady != '0)) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX:  state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
			hitflag_q   <= 1'b0;
			sel_q       <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					hitflag_q <= 1'b0;
					sel_q     <= '0;
				end
				ST_SQY:  cnt_q <= 6'd32;
				ST_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						sel_q <= sel_q + 2'd1;
					end
				end
				ST_CMP:  hitflag_q <= is_hit;
				ST_MUL:  cnt_q <= 6'd63;
				ST_DIV:  cnt_q <= cnt_q - 6'd1;
				ST_DONE: begin
					found_q <= j_q.last ? 1'b0 : (found_q || hitflag_q);
					if (emit) begin
						res_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (fifo_pop) begin
					j_q <= fifo_data;
				end
			end
			ST_SQX:  sq_q <= mul_p;
			ST_SQY: begin
				rad_q  <= RAD_W'(sq_q) + RAD_W'(mul_p);
				root_q <= '0;
				rem_q  <= '0;
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ok ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], sq_ok};
				if (cnt_q == '0) begin
					d_q[sel_q] <= {root_q[ROOT_W-2:0], sq_ok};
				end
			end
			ST_CMP: begin
				ixaxis_q <= adx > ady;
				nx_q     <= j_q.x1;
				ny_q     <= j_q.y1;
				if (adx > ady) begin
					ia_q    <= ey;
					ib_q    <= 33'(cfg.query_x) - 33'(j_q.x1);
					iden_q  <= ex;
					ibase_q <= j_q.y1;
				end else begin
					ia_q    <= ex;
					ib_q    <= 33'(cfg.query_y) - 33'(j_q.y1);
					iden_q  <= ey;
					ibase_q <= j_q.x1;
				end
			end
			ST_MUL: begin
				quo_q  <= mul_p;
				drem_q <= '0;
				neg_q  <= (ia_q != '0) && (ib_q != '0) && (ia_q[32] ^ ib_q[32] ^ iden_q[32]);
			end
			ST_DIV: begin
				quo_q  <= {quo_q[62:0], d_ok};
				drem_q <= d_ok ? 32'(dsh - {1'b0, mag33(iden_q)}) : dsh[31:0];
			end
			ST_FIX: begin
				if (ixaxis_q) begin
					nx_q <= cfg.query_x;
					ny_q <= vres;
				end else begin
					nx_q <= vres;
					ny_q <= cfg.query_y;
				end
			end
			ST_DONE: begin
				if (emit) begin
					hit          <= hitflag_q;
					insert_index <= hitflag_q ? j_q.index : '0;
					new_x        <= hitflag_q ? nx_q : '0;
					new_y        <= hitflag_q ? ny_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign empty = !res_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !res_valid_q)
		else $error("result register loaded while a result waits");
	a_root_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT && cnt_q == '0) |=> (state_q == ST_CMP || state_q == ST_SQX))
		else $error("square root finished into a wrong state");
	a_found_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && j_q.last) |=> !found_q)
		else $error("hit flag survived the last vertex");
`endif

endmodule
